>>> design/amvm_pkg.sv
// Shared constants, types and command struct for the AM voice modem FIR block.
// No dependencies; used by amvm_ctrl, amvm_dp and am_voice_modem_fir_top.
`default_nettype none
package amvm_pkg;

  localparam int TAPS  = 64;
  localparam int IDX_W = (TAPS > 4) ? $clog2(TAPS) : 2;
  localparam int ACC_W = 32 + IDX_W;

  localparam logic [1:0]  PH_POS   = 2'd0;
  localparam logic [1:0]  PH_NEG   = 2'd2;
  localparam logic        OP_PROC  = 1'b0;
  localparam logic        OP_LOAD  = 1'b1;
  localparam logic        FIL_BP   = 1'b0;
  localparam logic        FIL_LP   = 1'b1;
  localparam logic [15:0] VOL_RST  = 16'd32768;

  typedef struct packed {
    logic             take;     // sample beat accepted
    logic             hist_wr;  // push filter input into selected history
    logic             acc_clr;
    logic             issue;    // read one tap/history pair
    logic [IDX_W-1:0] k;
    logic             sel;      // filter selected for this pass
    logic             sat;      // store saturated filter result
    logic             mul;      // post-filter multiply
    logic             fin;      // load output code
  } cmd_t;

endpackage
`default_nettype wire

>>> design/amvm_dp.sv
// Datapath: histories, coefficient memories, shared MAC, post-scaling and output register.
// Depends on amvm_pkg; driven by amvm_ctrl.
`default_nettype none
module amvm_dp (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire amvm_pkg::cmd_t       cmd_i,
  input  wire logic                 load_i,
  input  wire logic [11:0]          sample_i,
  input  wire logic                 transmit_i,
  input  wire logic                 coef_filter_i,
  input  wire logic [5:0]           coef_index_i,
  input  wire logic signed [15:0]   coef_value_i,
  input  wire logic                 cfg_we_i,
  input  wire logic [15:0]          cfg_wdata_i,
  output logic [11:0]               dac_value_o
);

  localparam int IW = amvm_pkg::IDX_W;
  localparam int AW = amvm_pkg::ACC_W;
  localparam logic signed [AW-1:0] SMAX = AW'(32767);
  localparam logic signed [AW-1:0] SMIN = -AW'(32768);

  logic signed [15:0] bp_hist [amvm_pkg::TAPS];
  logic signed [15:0] lp_hist [amvm_pkg::TAPS];
  logic signed [15:0] bp_taps [amvm_pkg::TAPS];
  logic signed [15:0] lp_taps [amvm_pkg::TAPS];
  logic [amvm_pkg::TAPS-1:0] bp_hv_q, lp_hv_q;
  logic [IW-1:0] bp_wp_q, lp_wp_q, wp_nx, rd_addr, wp_cur;

  logic [15:0]        vol_q;
  logic [1:0]         phase_q, cur_ph_q;
  logic               tx_q;
  logic signed [15:0] x_q, res_q, neg_x, fir_in, h_q, t_q;
  logic               h_v_q, rd_v_q, prod_v_q;
  logic signed [31:0] prod_q;
  logic signed [AW-1:0] acc_q, acc_sh;
  logic signed [32:0] prod2_q, prod2_d;
  logic signed [17:0] env;
  logic signed [17:0] s_val;
  logic signed [18:0] code;
  logic [11:0]        dac_q;
  logic [IW-1:0]      tap_addr;

  assign tap_addr = IW'(coef_index_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vol_q   <= amvm_pkg::VOL_RST;
      phase_q <= 2'd0;
      bp_hv_q <= '0;
      lp_hv_q <= '0;
      bp_wp_q <= '0;
      lp_wp_q <= '0;
      rd_v_q  <= 1'b0;
      prod_v_q <= 1'b0;
    end else begin
      if (cfg_we_i) vol_q <= cfg_wdata_i;
      if (cmd_i.take) phase_q <= phase_q + 2'd1;
      if (cmd_i.hist_wr) begin
        if (cmd_i.sel == amvm_pkg::FIL_LP) begin
          lp_wp_q <= wp_nx;
          lp_hv_q[wp_nx] <= 1'b1;
        end else begin
          bp_wp_q <= wp_nx;
          bp_hv_q[wp_nx] <= 1'b1;
        end
      end
      rd_v_q   <= cmd_i.issue;
      prod_v_q <= rd_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      x_q      <= {~sample_i[11], sample_i[10:0], 4'b0000};
      tx_q     <= transmit_i;
      cur_ph_q <= phase_q;
    end
  end

  assign neg_x = (x_q == 16'sh8000) ? 16'sh7fff : -x_q;

  always_comb begin
    if (cmd_i.sel == amvm_pkg::FIL_LP) begin
      if (cur_ph_q == amvm_pkg::PH_POS)      fir_in = x_q;
      else if (cur_ph_q == amvm_pkg::PH_NEG) fir_in = neg_x;
      else                                   fir_in = '0;
    end else begin
      fir_in = tx_q ? x_q : res_q;
    end
  end

  assign wp_cur  = (cmd_i.sel == amvm_pkg::FIL_LP) ? lp_wp_q : bp_wp_q;
  assign wp_nx   = (wp_cur == IW'(amvm_pkg::TAPS - 1)) ? '0 : wp_cur + 1'b1;
  assign rd_addr = (wp_cur >= cmd_i.k) ? wp_cur - cmd_i.k
                                       : IW'(wp_cur + IW'(amvm_pkg::TAPS) - cmd_i.k);

  // history and coefficient memories
  always_ff @(posedge clk_i) begin
    if (cmd_i.hist_wr && cmd_i.sel == amvm_pkg::FIL_LP) lp_hist[wp_nx] <= fir_in;
    if (cmd_i.hist_wr && cmd_i.sel == amvm_pkg::FIL_BP) bp_hist[wp_nx] <= fir_in;
    if (load_i && 32'(coef_index_i) < amvm_pkg::TAPS) begin
      if (coef_filter_i == amvm_pkg::FIL_LP) lp_taps[tap_addr] <= coef_value_i;
      else                                   bp_taps[tap_addr] <= coef_value_i;
    end
    if (cmd_i.issue) begin
      if (cmd_i.sel == amvm_pkg::FIL_LP) begin
        h_q   <= lp_hist[rd_addr];
        h_v_q <= lp_hv_q[rd_addr];
        t_q   <= lp_taps[cmd_i.k];
      end else begin
        h_q   <= bp_hist[rd_addr];
        h_v_q <= bp_hv_q[rd_addr];
        t_q   <= bp_taps[cmd_i.k];
      end
    end
  end

  assign acc_sh = acc_q >>> 15;

  always_ff @(posedge clk_i) begin
    if (rd_v_q) prod_q <= h_v_q ? t_q * h_q : 32'sd0;
    if (cmd_i.acc_clr)  acc_q <= '0;
    else if (prod_v_q)  acc_q <= acc_q + AW'(prod_q);
    if (cmd_i.sat) begin
      if (acc_sh > SMAX)      res_q <= 16'sh7fff;
      else if (acc_sh < SMIN) res_q <= 16'sh8000;
      else                    res_q <= acc_sh[15:0];
    end
    if (cmd_i.mul) prod2_q <= prod2_d;
    if (cmd_i.fin) dac_q <= code[18] ? 12'd0 : (code > 19'sd4095) ? 12'd4095 : code[11:0];
  end

  assign prod2_d = res_q * (tx_q ? 17'sd13107 : $signed({1'b0, vol_q}));

  always_comb begin
    env = 18'sd16384 + 18'(prod2_q >>> 15);
    if (cur_ph_q == amvm_pkg::PH_POS)      s_val = env;
    else if (cur_ph_q == amvm_pkg::PH_NEG) s_val = -env;
    else                                   s_val = '0;
    if (tx_q) code = 19'sd2048 + 19'(s_val >>> 4);
    else      code = 19'sd2048 + 19'(prod2_q >>> 17);
  end

  assign dac_value_o = dac_q;

endmodule
`default_nettype wire

>>> design/amvm_ctrl.sv
// Controller state machine: sequences history push, MAC sweep, drain and post-scaling.
// Depends on amvm_pkg; commands amvm_dp.
`default_nettype none
module amvm_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  input  wire logic           op_i,
  input  wire logic           transmit_i,
  output logic                in_stall_o,
  output logic                load_o,
  input  wire logic           out_stall_i,
  output logic                out_valid_o,
  output amvm_pkg::cmd_t      cmd_o
);

  localparam int IW = amvm_pkg::IDX_W;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_HWR   = 7'b0000010,
    S_MAC   = 7'b0000100,
    S_DRAIN = 7'b0001000,
    S_SAT   = 7'b0010000,
    S_MUL   = 7'b0100000,
    S_FIN   = 7'b1000000
  } state_e;

  state_e        state_q, state_d;
  logic [IW-1:0] k_q, k_d;
  logic          sel_q, sel_d, ov_q, ov_d;
  logic          acc;
  logic          fin_ok;

  assign acc    = in_valid_i && (state_q == S_IDLE);
  assign fin_ok = !ov_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    k_d     = k_q;
    sel_d   = sel_q;
    ov_d    = ov_q && out_stall_i;
    cmd_o   = '0;
    cmd_o.k   = k_q;
    cmd_o.sel = sel_q;
    unique case (state_q)
      S_IDLE: begin
        if (acc && op_i == amvm_pkg::OP_PROC) begin
          cmd_o.take = 1'b1;
          sel_d   = transmit_i ? amvm_pkg::FIL_BP : amvm_pkg::FIL_LP;
          state_d = S_HWR;
        end
      end
      S_HWR: begin
        cmd_o.hist_wr = 1'b1;
        cmd_o.acc_clr = 1'b1;
        k_d     = '0;
        state_d = S_MAC;
      end
      S_MAC: begin
        cmd_o.issue = 1'b1;
        k_d = k_q + 1'b1;
        if (k_q == IW'(amvm_pkg::TAPS - 1)) begin
          k_d     = '0;
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        k_d = k_q + 1'b1;
        if (k_q == IW'(2)) state_d = S_SAT;
      end
      S_SAT: begin
        cmd_o.sat = 1'b1;
        if (sel_q == amvm_pkg::FIL_LP) begin
          sel_d   = amvm_pkg::FIL_BP;
          state_d = S_HWR;
        end else begin
          state_d = S_MUL;
        end
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = S_FIN;
      end
      S_FIN: begin
        if (fin_ok) begin
          cmd_o.fin = 1'b1;
          ov_d      = 1'b1;
          state_d   = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      k_q     <= '0;
      sel_q   <= amvm_pkg::FIL_BP;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      k_q     <= k_d;
      sel_q   <= sel_d;
      ov_q    <= ov_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign load_o      = acc && op_i == amvm_pkg::OP_LOAD;
  assign out_valid_o = ov_q;

endmodule
`default_nettype wire

>>> design/am_voice_modem_fir_top.sv
// AM voice modem with quarter-rate carrier and two 64-tap FIR filters.
// Instantiates amvm_ctrl and amvm_dp; depends on amvm_pkg.
//
// Usage:
// - Input channel (in_valid_i / in_stall_o) carries one beat per item. op_i = 0 processes
//   one converter sample, op_i = 1 loads one coefficient (no output beat is produced).
// - Output channel (out_valid_o / out_stall_i) carries one 12-bit code per sample beat.
// - cfg_we_i writes the receive volume (unsigned Q1.15) from cfg_wdata_i.
// Timing:
// - A coefficient beat is written when it is taken; the next beat may follow at once.
// - A transmit sample runs one filter pass; a receive sample runs two filter passes.
//   The single multiply-accumulate unit sweeps one tap per cycle, so the processing
//   time of a sample grows with TAPS.
// - The result sits in an output register; the next beat is accepted while it waits.
// Stall: a waiting result holds; a finished item then waits for the output register to free.
// Reset: histories read as zero (per-entry valid bits), carrier phase 0, volume 1.0.
// Coefficients are undefined until loaded.
`default_nettype none
module am_voice_modem_fir_top (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic               op_i,
  input  wire logic [11:0]        sample_i,
  input  wire logic               transmit_i,
  input  wire logic               coef_filter_i,
  input  wire logic [5:0]         coef_index_i,
  input  wire logic signed [15:0] coef_value_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic [11:0]             dac_value_o,
  input  wire logic               cfg_we_i,
  input  wire logic [15:0]        cfg_wdata_i
);

  amvm_pkg::cmd_t cmd;
  logic           load;

  // sequence each beat
  amvm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .op_i        (op_i),
    .transmit_i  (transmit_i),
    .in_stall_o  (in_stall_o),
    .load_o      (load),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .cmd_o       (cmd)
  );

  // filters, scaling and output register
  amvm_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .load_i        (load),
    .sample_i      (sample_i),
    .transmit_i    (transmit_i),
    .coef_filter_i (coef_filter_i),
    .coef_index_i  (coef_index_i),
    .coef_value_i  (coef_value_i),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .dac_value_o   (dac_value_o)
  );

endmodule
`default_nettype wire

>>> design/amvm_chk.sv
// Port-level checker for am_voice_modem_fir_top, bound onto the top level.
// No package dependencies.
`default_nettype none
module amvm_chk (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_stall_o,
  input wire logic        op_i,
  input wire logic        out_valid_o,
  input wire logic        out_stall_i,
  input wire logic [11:0] dac_value_o
);

  // hold a stalled output beat
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(dac_value_o))
    else $error("stalled output beat changed");

  // a sample beat keeps the block busy next cycle
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && !op_i |=> in_stall_o)
    else $error("no busy after sample beat");

  // a coefficient beat leaves the input open
  a_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && op_i |=> !in_stall_o)
    else $error("coefficient load stalled input");

  // a new result only comes out of a busy block
  a_res: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result without processing");

endmodule

bind am_voice_modem_fir_top amvm_chk u_amvm_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .op_i        (op_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .dac_value_o (dac_value_o)
);
`default_nettype wire
